>>> rtl/core/mlp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mlp_pkg
// Types, codes and constant tables shared by the network inference core.
// ----------------------------------------------------------------------------
package mlp_pkg;

    localparam int UnitsMax   = 16;
    localparam int FracBits   = 12;
    localparam int TableDepth = 256;
    localparam int AccW       = 40;

    localparam logic [1:0] KIND_WEIGHT = 2'd0;
    localparam logic [1:0] KIND_BIAS   = 2'd1;
    localparam logic [1:0] KIND_SAMPLE = 2'd2;

    localparam logic [1:0] ACT_RELU = 2'd0;
    localparam logic [1:0] ACT_TANH = 2'd1;
    localparam logic [1:0] ACT_SIGM = 2'd2;

    localparam logic [2:0] REG_ACT_MODE = 3'd0;
    localparam logic [2:0] REG_HIDDEN   = 3'd1;
    localparam logic [2:0] REG_INPUTS   = 3'd2;
    localparam logic [2:0] REG_OUTPUTS  = 3'd3;
    localparam logic [2:0] REG_UNITS0   = 3'd4;
    localparam logic [2:0] REG_UNITS1   = 3'd5;
    localparam logic [2:0] REG_UNITS2   = 3'd6;

    typedef struct packed {
        logic [1:0]         kind;
        logic [1:0]         layer_sel;
        logic [3:0]         row_sel;
        logic [3:0]         col_sel;
        logic signed [15:0] value;
        logic               end_of_vector;
    } mlp_in_t;

    typedef struct packed {
        logic signed [15:0] out_value;
        logic [3:0]         out_index;
        logic               out_last;
    } mlp_out_t;

    typedef struct packed {
        logic       bias_rd;
        logic       acc_load;
        logic       issue;
        logic       fin;
        logic       store_hidden;
        logic       load_out;
        logic       out_last;
        logic [1:0] layer;
        logic [3:0] row;
        logic [3:0] col;
        logic       src_a;
        logic       src_bank;
        logic       dst_bank;
    } mlp_cmd_t;

    typedef struct packed {
        logic pipe_busy;
        logic out_done;
    } mlp_status_t;

    typedef logic [TableDepth-1:0][15:0] act_table_t;

    localparam longint unsigned Q30One = 64'd1 << 30;

    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned quo;
        logic [64:0]     rem;
        quo = '0;
        rem = '0;
        for (int bit_pos = 63; bit_pos >= 0; bit_pos--) begin
            rem = {rem[63:0], num[bit_pos]};
            if (rem >= {1'b0, den}) begin
                rem          = rem - {1'b0, den};
                quo[bit_pos] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic longint unsigned exp_frac(input longint unsigned f);
        longint unsigned sum;
        longint unsigned term;
        sum  = Q30One;
        term = Q30One;
        for (int n = 1; n <= 24; n++) begin
            term = udiv64((term * f) >> 30, 64'(n));
            sum  = sum + term;
        end
        return sum;
    endfunction

    function automatic longint unsigned exp_neg(input longint unsigned t);
        longint unsigned e1;
        longint unsigned inv_e;
        longint unsigned ef;
        longint unsigned r;
        longint unsigned whole;
        e1    = exp_frac(Q30One);
        inv_e = udiv64((Q30One << 30) + e1 / 2, e1);
        ef    = exp_frac(t & (Q30One - 1));
        r     = udiv64((Q30One << 30) + ef / 2, ef);
        whole = t >> 30;
        for (longint unsigned i = 0; i < whole; i++) begin
            r = (r * inv_e + (Q30One >> 1)) >> 30;
        end
        return r;
    endfunction

    function automatic logic [15:0] q30_to_q(input longint unsigned s);
        longint unsigned q;
        q = (s + (64'd1 << (29 - FracBits))) >> (30 - FracBits);
        return (q > 64'd32767) ? 16'd32767 : q[15:0];
    endfunction

    function automatic act_table_t build_act_table(input logic is_tanh);
        act_table_t      tbl;
        longint          num;
        longint unsigned mag;
        longint unsigned t;
        longint unsigned t2;
        longint unsigned e;
        longint unsigned e2;
        longint unsigned s;
        longint unsigned th;
        logic [15:0]     tq;
        for (int k = 0; k < TableDepth; k++) begin
            num = 16 * longint'(k) + 8 - 8 * longint'(TableDepth);
            mag = (num < 0) ? longint'(-num) : longint'(num);
            t   = ((mag << 30) + TableDepth / 2) / TableDepth;
            t2  = ((mag << 31) + TableDepth / 2) / TableDepth;
            e   = exp_neg(t);
            e2  = exp_neg(t2);
            if (is_tanh) begin
                th = udiv64(((Q30One - e2) << 30) + (Q30One + e2) / 2, Q30One + e2);
                tq = q30_to_q(th);
                tbl[k] = (num < 0) ? 16'(-tq) : tq;
            end else begin
                if (num >= 0) begin
                    s = udiv64((Q30One << 30) + (Q30One + e) / 2, Q30One + e);
                end else begin
                    s = udiv64((e << 30) + (Q30One + e) / 2, Q30One + e);
                end
                tbl[k] = q30_to_q(s);
            end
        end
        return tbl;
    endfunction

    localparam act_table_t TANH_TABLE = build_act_table(1'b1);
    localparam act_table_t SIGM_TABLE = build_act_table(1'b0);

endpackage
`default_nettype wire

>>> rtl/core/mlp_forward_inference_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mlp_forward_inference_core
// Fully connected network inference in Q4.12 with one shared MAC unit.
//
//   Channel  Direction  Handshake          Payload
//   s_       in         s_valid/s_ready    mlp_in_t
//   m_       out        m_valid/m_ready    mlp_out_t
//   cfg_     in         cfg_we             cfg_index, cfg_wdata
//
// Weight, bias and sample items are taken one per cycle, but none while a pass
// runs. Per neuron the sequencer reads the bias, loads the accumulator, feeds
// the n inputs of the layer to the single MAC, drains the pipe and rounds; the
// result is activated and stored, or in the output layer held raw on m_ until
// m_ready takes it. Reset is synchronous and active low.
// ----------------------------------------------------------------------------
module mlp_forward_inference_core (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire mlp_pkg::mlp_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output mlp_pkg::mlp_out_t      m_data,
    input  wire logic              cfg_we,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [4:0]        cfg_wdata
);
    import mlp_pkg::*;

    logic [1:0]  act_mode_reg;
    logic [1:0]  hidden_reg;
    logic [4:0]  inputs_reg;
    logic [4:0]  outputs_reg;
    logic [4:0]  units0_reg;
    logic [4:0]  units1_reg;
    logic [4:0]  units2_reg;
    logic        idle;
    logic        in_accept;
    logic        start;
    mlp_cmd_t    cmd;
    mlp_status_t status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_mode_reg <= ACT_RELU;
            hidden_reg   <= 2'd1;
            inputs_reg   <= 5'd1;
            outputs_reg  <= 5'd1;
            units0_reg   <= 5'd1;
            units1_reg   <= 5'd1;
            units2_reg   <= 5'd1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_ACT_MODE: act_mode_reg <= cfg_wdata[1:0];
                REG_HIDDEN:   hidden_reg   <= cfg_wdata[1:0];
                REG_INPUTS:   inputs_reg   <= cfg_wdata;
                REG_OUTPUTS:  outputs_reg  <= cfg_wdata;
                REG_UNITS0:   units0_reg   <= cfg_wdata;
                REG_UNITS1:   units1_reg   <= cfg_wdata;
                REG_UNITS2:   units2_reg   <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign s_ready   = idle;
    assign in_accept = s_valid & idle;
    assign start     = in_accept && s_data.kind == KIND_SAMPLE && s_data.end_of_vector;

    mlp_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (start),
        .hidden_count (hidden_reg),
        .input_count  (inputs_reg),
        .output_count (outputs_reg),
        .units0       (units0_reg),
        .units1       (units1_reg),
        .units2       (units2_reg),
        .status       (status),
        .cmd          (cmd),
        .idle         (idle)
    );

    mlp_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_data   (s_data),
        .cmd       (cmd),
        .act_mode  (act_mode_reg),
        .m_ready   (m_ready),
        .status    (status),
        .m_valid   (m_valid),
        .m_data    (m_data)
    );

endmodule
`default_nettype wire

>>> rtl/core/mlp_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mlp_datapath
// Weight, bias and vector memories, the shared multiply-accumulate unit,
// rounding, activation and the output register.
// ----------------------------------------------------------------------------
module mlp_datapath (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_accept,
    input  wire mlp_pkg::mlp_in_t     in_data,
    input  wire mlp_pkg::mlp_cmd_t    cmd,
    input  wire logic [1:0]           act_mode,
    input  wire logic                 m_ready,
    output mlp_pkg::mlp_status_t      status,
    output logic                      m_valid,
    output mlp_pkg::mlp_out_t         m_data
);
    import mlp_pkg::*;

    logic signed [15:0] weight_mem [0:1023];
    logic signed [15:0] bias_mem [0:63];
    logic signed [15:0] buf_a [0:UnitsMax-1];
    logic signed [15:0] work0 [0:UnitsMax-1];
    logic signed [15:0] work1 [0:UnitsMax-1];

    logic [4:0]              sample_cnt_reg;
    logic                    v1_reg;
    logic                    v2_reg;
    logic signed [15:0]      w_reg;
    logic signed [15:0]      x_reg;
    logic signed [15:0]      b_reg;
    logic signed [31:0]      prod_reg;
    logic signed [AccW-1:0]  acc_reg;
    logic signed [15:0]      res_reg;
    logic                    m_valid_reg;
    mlp_out_t                out_reg;

    logic signed [AccW-1:0]  rnd;
    logic signed [AccW-13:0] shifted;
    logic signed [15:0]      sat;
    logic signed [15:0]      act_val;
    logic [7:0]              tidx;

    always_ff @(posedge aclk) begin
        if (in_accept && in_data.kind == KIND_WEIGHT) begin
            weight_mem[{in_data.layer_sel, in_data.row_sel, in_data.col_sel}] <= in_data.value;
        end
        if (cmd.issue) begin
            w_reg <= weight_mem[{cmd.layer, cmd.row, cmd.col}];
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept && in_data.kind == KIND_BIAS) begin
            bias_mem[{in_data.layer_sel, in_data.row_sel}] <= in_data.value;
        end
        if (cmd.bias_rd) begin
            b_reg <= bias_mem[{cmd.layer, cmd.row}];
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept && in_data.kind == KIND_SAMPLE && !sample_cnt_reg[4]) begin
            buf_a[sample_cnt_reg[3:0]] <= in_data.value;
        end
        if (cmd.store_hidden && !cmd.dst_bank) begin
            work0[cmd.row] <= act_val;
        end
        if (cmd.store_hidden && cmd.dst_bank) begin
            work1[cmd.row] <= act_val;
        end
        if (cmd.issue) begin
            if (cmd.src_a) begin
                x_reg <= buf_a[cmd.col];
            end else if (cmd.src_bank) begin
                x_reg <= work1[cmd.col];
            end else begin
                x_reg <= work0[cmd.col];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_cnt_reg <= '0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (in_accept && in_data.kind == KIND_SAMPLE) begin
                if (in_data.end_of_vector) begin
                    sample_cnt_reg <= '0;
                end else if (!sample_cnt_reg[4]) begin
                    sample_cnt_reg <= sample_cnt_reg + 5'd1;
                end
            end
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= w_reg * x_reg;
        if (cmd.acc_load) begin
            acc_reg <= AccW'(b_reg) <<< FracBits;
        end else if (v2_reg) begin
            acc_reg <= acc_reg + AccW'(prod_reg);
        end
        if (cmd.fin) begin
            res_reg <= sat;
        end
        if (cmd.load_out) begin
            out_reg.out_value <= res_reg;
            out_reg.out_index <= cmd.row;
            out_reg.out_last  <= cmd.out_last;
        end
    end

    always_comb begin
        rnd     = acc_reg + AccW'(1 << (FracBits - 1));
        shifted = rnd[AccW-1:FracBits];
        if (shifted > 28'sd32767) begin
            sat = 16'sd32767;
        end else if (shifted < -28'sd32768) begin
            sat = -16'sd32768;
        end else begin
            sat = shifted[15:0];
        end
    end

    always_comb begin
        tidx = {~res_reg[15], res_reg[14:8]};
        case (act_mode)
            ACT_TANH: act_val = TANH_TABLE[tidx];
            ACT_SIGM: act_val = SIGM_TABLE[tidx];
            default:  act_val = res_reg[15] ? 16'sd0 : res_reg;
        endcase
    end

    assign status.pipe_busy = v1_reg | v2_reg;
    assign status.out_done  = m_valid_reg & m_ready;
    assign m_valid          = m_valid_reg;
    assign m_data           = out_reg;

endmodule
`default_nettype wire

>>> rtl/core/mlp_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mlp_ctrl
// Sequencer for the forward pass: walks layers, neurons and columns.
// ----------------------------------------------------------------------------
module mlp_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic [1:0]           hidden_count,
    input  wire logic [4:0]           input_count,
    input  wire logic [4:0]           output_count,
    input  wire logic [4:0]           units0,
    input  wire logic [4:0]           units1,
    input  wire logic [4:0]           units2,
    input  wire mlp_pkg::mlp_status_t status,
    output mlp_pkg::mlp_cmd_t         cmd,
    output logic                      idle
);
    import mlp_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_LAYER  = 9'b000000010,
        ST_NEURON = 9'b000000100,
        ST_BIAS   = 9'b000001000,
        ST_MAC    = 9'b000010000,
        ST_DRAIN  = 9'b000100000,
        ST_FIN    = 9'b001000000,
        ST_STORE  = 9'b010000000,
        ST_OUT    = 9'b100000000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] layer_reg, layer_next;
    logic [3:0] row_reg, row_next;
    logic [3:0] col_reg, col_next;
    logic [4:0] n_reg, n_next;
    logic [4:0] m_reg, m_next;
    logic [4:0] m_cfg;
    logic       at_out_layer;
    logic       last_row;

    function automatic logic [4:0] clamp(input logic [4:0] v);
        return (v > 5'(UnitsMax)) ? 5'(UnitsMax) : v;
    endfunction

    assign at_out_layer = (layer_reg == hidden_count);
    assign last_row     = ({1'b0, row_reg} == m_reg - 5'd1);

    always_comb begin
        if (at_out_layer) begin
            m_cfg = clamp(output_count);
        end else if (layer_reg == 2'd0) begin
            m_cfg = clamp(units0);
        end else if (layer_reg == 2'd1) begin
            m_cfg = clamp(units1);
        end else begin
            m_cfg = clamp(units2);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            layer_reg <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            n_reg     <= '0;
            m_reg     <= '0;
        end else begin
            state_reg <= state_next;
            layer_reg <= layer_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            n_reg     <= n_next;
            m_reg     <= m_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        layer_next = layer_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        n_next     = n_reg;
        m_next     = m_reg;
        cmd        = '0;
        cmd.layer  = layer_reg;
        cmd.row    = row_reg;
        cmd.col    = col_reg;
        cmd.src_a  = (layer_reg == 2'd0);
        cmd.src_bank = ~layer_reg[0];
        cmd.dst_bank = layer_reg[0];
        cmd.out_last = last_row;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    layer_next = '0;
                    n_next     = clamp(input_count);
                    state_next = ST_LAYER;
                end
            end
            ST_LAYER: begin
                m_next   = m_cfg;
                row_next = '0;
                if (m_cfg == 5'd0) begin
                    if (at_out_layer) begin
                        state_next = ST_IDLE;
                    end else begin
                        layer_next = layer_reg + 2'd1;
                        n_next     = '0;
                    end
                end else begin
                    state_next = ST_NEURON;
                end
            end
            ST_NEURON: begin
                cmd.bias_rd = 1'b1;
                col_next    = '0;
                state_next  = ST_BIAS;
            end
            ST_BIAS: begin
                cmd.acc_load = 1'b1;
                state_next   = (n_reg == 5'd0) ? ST_DRAIN : ST_MAC;
            end
            ST_MAC: begin
                cmd.issue = 1'b1;
                col_next  = col_reg + 4'd1;
                if ({1'b0, col_reg} == n_reg - 5'd1) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!status.pipe_busy) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                cmd.fin    = 1'b1;
                state_next = ST_STORE;
            end
            ST_STORE: begin
                if (at_out_layer) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_OUT;
                end else begin
                    cmd.store_hidden = 1'b1;
                    if (last_row) begin
                        layer_next = layer_reg + 2'd1;
                        n_next     = m_reg;
                        state_next = ST_LAYER;
                    end else begin
                        row_next   = row_reg + 4'd1;
                        state_next = ST_NEURON;
                    end
                end
            end
            ST_OUT: begin
                if (status.out_done) begin
                    if (last_row) begin
                        state_next = ST_IDLE;
                    end else begin
                        row_next   = row_reg + 4'd1;
                        state_next = ST_NEURON;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign idle = (state_reg == ST_IDLE);

endmodule
`default_nettype wire
